// File: sv/rrq_pkg.sv
package rrq_pkg;

   // Queue geometry
   localparam int MAX_ENTRIES = 16;
   localparam int PID_BITS    = 16;
   localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int RT_BITS     = 16;

   localparam logic [RT_BITS-1:0] QUANTUM_RESET = RT_BITS'(300);

   // Request kinds
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_NEXT    = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [PID_BITS-1:0] pid;
      logic                has_current;
      logic [RT_BITS-1:0]  runtime;
   } rrq_req_type;

   typedef struct packed {
      logic                status;
      logic                result_valid;
      logic [PID_BITS-1:0] result_pid;
      logic                quantum_expired;
   } rrq_rsp_type;

endpackage

// File: sv/round_robin_run_queue.sv
// Channel  Direction  Payload                      Transaction when
// req      in         rrq_pkg::rrq_req_type        req_valid & req_ready
// rsp      out        rrq_pkg::rrq_rsp_type        rsp_valid & rsp_ready
// csr      in         quantum_limit, 16 bits       csr_valid & csr_ready
//
// Enqueue goes from accept straight to the result state; dequeue, next and tick walk the
// queue through the single read port of the entry RAM, one entry per cycle.
// Synchronous active-high reset empties the queue and loads quantum 300.
// A result waits in the output register while rsp_ready is low; the next
// request is accepted meanwhile, and its result is handed over once the output frees.
module round_robin_run_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rrq_pkg::rrq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rrq_pkg::rrq_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } rrq_state_type;

   rrq_state_type state_ff, state_in;

   logic [rrq_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [rrq_pkg::CNT_BITS-1:0] issue_ff, issue_in;
   logic [rrq_pkg::IDX_BITS-1:0] data_idx_ff, data_idx_in;
   logic                         data_vld_ff, data_vld_in;
   logic                         found_ff, found_in;
   logic                         got_nxt_ff, got_nxt_in;
   logic [rrq_pkg::PID_BITS-1:0] head_ff, head_in;
   logic [rrq_pkg::PID_BITS-1:0] nxt_ff, nxt_in;
   logic [rrq_pkg::RT_BITS-1:0]  quantum_ff, quantum_in;
   rrq_pkg::rrq_req_type         req_ff, req_in;
   rrq_pkg::rrq_rsp_type         res_ff, res_in;
   rrq_pkg::rrq_rsp_type         rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         req_accept;
   logic                         scan_done;
   logic                         hit;
   logic                         out_free;
   logic                         rd_en;
   logic [rrq_pkg::PID_BITS-1:0] rd_data;
   logic                         wr_en;
   logic [rrq_pkg::IDX_BITS-1:0] wr_addr;
   logic [rrq_pkg::PID_BITS-1:0] wr_data;
   logic                         nxt_valid;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Scan pipeline: issue one read per cycle, look at the data in the cycle after the read
   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign scan_done = (state_ff == ST_SCAN) && (issue_ff == count_ff) && !data_vld_ff;
   assign hit       = data_vld_ff && !found_ff && (rd_data == req_ff.pid);

   // RAM write: append on enqueue, shift down behind the removed entry on dequeue
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[rrq_pkg::IDX_BITS-1:0];
      wr_data = req_data.pid;
      if (req_accept && (req_data.req_type == rrq_pkg::OP_ENQUEUE)
          && (count_ff < rrq_pkg::CNT_BITS'(rrq_pkg::MAX_ENTRIES))) begin
         wr_en = 1'b1;
      end else if ((state_ff == ST_SCAN) && data_vld_ff && found_ff
                   && (req_ff.req_type == rrq_pkg::OP_DEQUEUE)) begin
         wr_en   = 1'b1;
         wr_addr = data_idx_ff - rrq_pkg::IDX_BITS'(1);
         wr_data = rd_data;
      end
   end

   rrq_ram #(
      .WIDTH(rrq_pkg::PID_BITS),
      .DEPTH(rrq_pkg::MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[rrq_pkg::IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   // Answer valid for next: with a current pid it needs a match, else a non-empty queue
   assign nxt_valid = req_ff.has_current ? found_ff : (count_ff != '0);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      data_idx_in  = data_idx_ff;
      data_vld_in  = rd_en;
      found_in     = found_ff;
      got_nxt_in   = got_nxt_ff;
      head_in      = head_ff;
      nxt_in       = nxt_ff;
      quantum_in   = quantum_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid && csr_ready) begin
         quantum_in = csr_data;
      end

      if (rd_en) begin
         issue_in    = issue_ff + rrq_pkg::CNT_BITS'(1);
         data_idx_in = issue_ff[rrq_pkg::IDX_BITS-1:0];
      end

      // Track head, first match and the entry after it
      if (data_vld_ff) begin
         if (data_idx_ff == '0) begin
            head_in = rd_data;
         end
         if (hit) begin
            found_in = 1'b1;
         end
         if (found_ff && !got_nxt_ff) begin
            got_nxt_in = 1'b1;
            nxt_in     = rd_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in     = req_data;
               issue_in   = '0;
               found_in   = 1'b0;
               got_nxt_in = 1'b0;
               res_in     = '0;
               if (req_data.req_type == rrq_pkg::OP_ENQUEUE) begin
                  if (count_ff < rrq_pkg::CNT_BITS'(rrq_pkg::MAX_ENTRIES)) begin
                     count_in = count_ff + rrq_pkg::CNT_BITS'(1);
                  end else begin
                     res_in.status = 1'b1;
                  end
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               res_in = '0;
               case (req_ff.req_type)
                  rrq_pkg::OP_DEQUEUE: begin
                     if (found_ff) begin
                        count_in = count_ff - rrq_pkg::CNT_BITS'(1);
                     end else begin
                        res_in.status = 1'b1;
                     end
                  end
                  rrq_pkg::OP_NEXT: begin
                     res_in.result_valid = nxt_valid;
                     if (nxt_valid) begin
                        res_in.result_pid = (req_ff.has_current && got_nxt_ff) ?
                                            nxt_ff : head_ff;
                     end
                  end
                  rrq_pkg::OP_TICK: begin
                     res_in.quantum_expired = found_ff && (req_ff.runtime >= quantum_ff);
                  end
                  default: begin
                  end
               endcase
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // Hand the result over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         data_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         got_nxt_ff   <= 1'b0;
         quantum_ff   <= rrq_pkg::QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         data_vld_ff  <= data_vld_in;
         found_ff     <= found_in;
         got_nxt_ff   <= got_nxt_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      data_idx_ff <= data_idx_in;
      head_ff     <= head_in;
      nxt_ff      <= nxt_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Queue never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= rrq_pkg::CNT_BITS'(rrq_pkg::MAX_ENTRIES))
      else $error("queue count exceeds capacity");

   // Shift writes happen only behind a found entry of a dequeue
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && wr_en) |->
         (found_ff && (req_ff.req_type == rrq_pkg::OP_DEQUEUE) && (data_idx_ff != '0)))
      else $error("shift write without a match");

   // A successful dequeue drops the count by one
   assert property (@(posedge clock) disable iff (reset)
      (scan_done && found_ff && (req_ff.req_type == rrq_pkg::OP_DEQUEUE)) |=>
         (count_ff == ($past(count_ff) - rrq_pkg::CNT_BITS'(1))))
      else $error("dequeue did not shrink the queue");

   // Reads stay below the fill count
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_ff < count_ff) && (state_ff == ST_SCAN))
      else $error("read issued outside the scan");

endmodule

// File: sv/rrq_ram.sv
module rrq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
